@@ src/lsg_pkg.sv @@
package lsg_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CCNT_W   = $clog2(MAX_COLS + 1);
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int ROW_BITS = 2 * MAX_COLS;
    localparam int ADDR_W   = ROW_W + 1;

    localparam logic [1:0] CELL_EMPTY  = 2'd0;
    localparam logic [1:0] CELL_DUST   = 2'd1;
    localparam logic [1:0] CELL_NEBULA = 2'd2;
    localparam logic [1:0] CELL_ROCK   = 2'd3;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_GEN   = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [3:0] CFG_COLS = 4'd0;
    localparam logic [3:0] CFG_ROWS = 4'd1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] cell_in;
    } in_t;

    typedef struct packed {
        logic [1:0] cell_out;
        logic       buildable;
        logic       in_grid;
        logic       done_res;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_RW_FIN,
        ST_GEN_INIT,
        ST_GEN_FILL,
        ST_GEN_NEXT,
        ST_GEN_CELL,
        ST_GEN_WB,
        ST_GEN_FLIP
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;
        logic item_load;
        logic rd_item;
        logic rw_finish;
        logic gen_init;
        logic gen_fill;
        logic gen_next;
        logic gen_cell;
        logic gen_wb;
        logic gen_flip;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] func;
        logic       col_last;
        logic       row_last;
        logic       out_busy;
    } status_t;

    function automatic int clamp_dim(logic [6:0] v, int maxv);
        int r;
        r = int'(v);
        if (r == 0)
            r = 1;
        if (r > maxv)
            r = maxv;
        return r;
    endfunction

    function automatic logic [1:0] next_cell(logic [1:0] cur, logic [3:0] n, logic diag0);
        logic [1:0] r;
        case (cur)
            CELL_EMPTY:  r = (n == 4'd3) ? CELL_DUST : CELL_EMPTY;
            CELL_DUST:
            begin
                if (n == 4'd2 || n == 4'd3)
                    r = CELL_DUST;
                else if (n >= 4'd4)
                    r = CELL_NEBULA;
                else
                    r = CELL_EMPTY;
            end
            CELL_NEBULA:
            begin
                if (n <= 4'd1)
                    r = CELL_DUST;
                else if (n >= 4'd6 && diag0)
                    r = CELL_ROCK;
                else
                    r = CELL_NEBULA;
            end
            default:     r = (n == 4'd0) ? CELL_EMPTY : CELL_ROCK;
        endcase
        return r;
    endfunction

endpackage

@@ src/four_state_life_grid_stepper.sv @@
// channel   direction  handshake                 payload
// in_item   input      in_valid / in_ready       lsg_pkg::in_t
// out_item  output     out_valid / out_ready     lsg_pkg::out_t
// cfg       input      cfg_valid / cfg_ready     cfg_index[3:0], cfg_data[6:0]
//
// Write and read: one row read-modify-write, with the result registered.
// Generation: one cell per cycle out of a three-row window, one memory row read and written
// per grid row.
// After reset a clearing pass over the MAX_ROWS rows of bank 0 (one row a cycle) runs before
// the first transaction; config writes are always taken.
// A result held by out_ready low lets one more transaction in, which then waits in
// its last cycle; in_ready stays low until the held result leaves.
module four_state_life_grid_stepper
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lsg_pkg::in_t   in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output lsg_pkg::out_t  out_item,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_index,
    input  logic [6:0]     cfg_data
);

    lsg_pkg::cmd_t    cmd;
    lsg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lsg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsg_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

@@ src/lsg_ctrl.sv @@
module lsg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsg_pkg::status_t  status,
    output lsg_pkg::cmd_t     cmd
);

    lsg_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lsg_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lsg_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = lsg_pkg::ST_IDLE;
            end
            lsg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = lsg_pkg::ST_DISPATCH;
                end
            end
            lsg_pkg::ST_DISPATCH:
            begin
                if (status.func == lsg_pkg::FUNC_GEN)
                    state_next = lsg_pkg::ST_GEN_INIT;
                else
                begin
                    cmd.rd_item = 1'b1;
                    state_next  = lsg_pkg::ST_RW_FIN;
                end
            end
            lsg_pkg::ST_RW_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.rw_finish = 1'b1;
                    state_next    = lsg_pkg::ST_IDLE;
                end
            end
            lsg_pkg::ST_GEN_INIT:
            begin
                cmd.gen_init = 1'b1;
                state_next   = lsg_pkg::ST_GEN_FILL;
            end
            lsg_pkg::ST_GEN_FILL:
            begin
                cmd.gen_fill = 1'b1;
                state_next   = lsg_pkg::ST_GEN_NEXT;
            end
            lsg_pkg::ST_GEN_NEXT:
            begin
                cmd.gen_next = 1'b1;
                state_next   = lsg_pkg::ST_GEN_CELL;
            end
            lsg_pkg::ST_GEN_CELL:
            begin
                cmd.gen_cell = 1'b1;
                if (status.col_last)
                    state_next = lsg_pkg::ST_GEN_WB;
            end
            lsg_pkg::ST_GEN_WB:
            begin
                cmd.gen_wb = 1'b1;
                state_next = status.row_last ? lsg_pkg::ST_GEN_FLIP : lsg_pkg::ST_GEN_NEXT;
            end
            lsg_pkg::ST_GEN_FLIP:
            begin
                if (!status.out_busy)
                begin
                    cmd.gen_flip = 1'b1;
                    state_next   = lsg_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lsg_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ src/lsg_datapath.sv @@
module lsg_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  lsg_pkg::cmd_t     cmd,
    output lsg_pkg::status_t  status,
    input  lsg_pkg::in_t      in_item,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    output lsg_pkg::out_t     out_item,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int RB = lsg_pkg::ROW_BITS;

    // one row of cells per word; bank in the top address bit
    logic [RB-1:0] mem [2*lsg_pkg::MAX_ROWS];
    logic [RB-1:0] rd_data_reg;

    logic [lsg_pkg::CCNT_W-1:0] cols_reg;
    logic [lsg_pkg::RCNT_W-1:0] rows_reg;
    logic                       bank_reg;
    lsg_pkg::in_t               item_reg;
    lsg_pkg::out_t              out_reg;
    logic                       out_valid_reg;

    logic [lsg_pkg::ROW_W-1:0]  clr_row_reg;
    logic [RB-1:0]              prev_reg, cur_reg, next_reg, new_row_reg;
    logic [lsg_pkg::RCNT_W-1:0] gen_row_reg;
    logic [lsg_pkg::COL_W-1:0]  gen_col_reg;
    logic [2:0]                 rowmod_reg, diag_reg;

    logic                       rd_en, wr_en;
    logic [lsg_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic [RB-1:0]              wr_data, mod_row;
    logic                       addr_hit;
    logic [lsg_pkg::COL_W-1:0]  item_col;
    logic [lsg_pkg::ROW_W-1:0]  item_row;
    logic [1:0]                 rd_cell;
    lsg_pkg::out_t              rw_out;

    logic [lsg_pkg::COL_W-1:0]  cm1, cp1;
    logic                       vm1, vp1;
    logic [7:0]                 nb;
    logic [3:0]                 n_cnt;
    logic [1:0]                 center, new_cell;
    logic                       next_row_in;

    function automatic logic dense(logic [1:0] v);
        return (v == lsg_pkg::CELL_DUST) || (v == lsg_pkg::CELL_NEBULA);
    endfunction

    assign item_col = lsg_pkg::COL_W'(item_reg.col);
    assign item_row = lsg_pkg::ROW_W'(item_reg.row);
    assign addr_hit = (item_reg.col < cols_reg) && (item_reg.row < rows_reg);
    assign rd_cell  = rd_data_reg[2*item_col +: 2];

    always_comb
    begin
        mod_row              = rd_data_reg;
        mod_row[2*item_col +: 2] = item_reg.cell_in;
    end

    always_comb
    begin
        rw_out          = '0;
        rw_out.in_grid  = addr_hit && (item_reg.func == lsg_pkg::FUNC_WRITE ||
                                       item_reg.func == lsg_pkg::FUNC_READ);
        rw_out.done_res = (item_reg.func == lsg_pkg::FUNC_WRITE);
        if (addr_hit && item_reg.func == lsg_pkg::FUNC_READ)
        begin
            rw_out.cell_out  = rd_cell;
            rw_out.buildable = dense(rd_cell);
        end
    end

    // neighbor window around gen_col_reg
    assign cm1 = gen_col_reg - 1'b1;
    assign cp1 = gen_col_reg + 1'b1;
    assign vm1 = (gen_col_reg != '0);
    assign vp1 = (lsg_pkg::CCNT_W'(gen_col_reg) + 1'b1) < cols_reg;

    always_comb
    begin
        nb[0] = vm1 && dense(prev_reg[2*cm1 +: 2]);
        nb[1] = dense(prev_reg[2*gen_col_reg +: 2]);
        nb[2] = vp1 && dense(prev_reg[2*cp1 +: 2]);
        nb[3] = vm1 && dense(cur_reg[2*cm1 +: 2]);
        nb[4] = vp1 && dense(cur_reg[2*cp1 +: 2]);
        nb[5] = vm1 && dense(next_reg[2*cm1 +: 2]);
        nb[6] = dense(next_reg[2*gen_col_reg +: 2]);
        nb[7] = vp1 && dense(next_reg[2*cp1 +: 2]);
        n_cnt = '0;
        for (int i = 0; i < 8; i++)
            n_cnt = n_cnt + {3'b000, nb[i]};
    end

    assign center      = cur_reg[2*gen_col_reg +: 2];
    assign new_cell    = lsg_pkg::next_cell(center, n_cnt, diag_reg == 3'd0);
    assign next_row_in = (gen_row_reg + 1'b1) < rows_reg;

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.rd_item)
        begin
            rd_en   = 1'b1;
            rd_addr = {bank_reg, item_row};
        end
        else if (cmd.gen_init)
        begin
            rd_en   = 1'b1;
            rd_addr = {bank_reg, lsg_pkg::ROW_W'(0)};
        end
        else if (cmd.gen_fill)
        begin
            rd_en   = 1'b1;
            rd_addr = {bank_reg, lsg_pkg::ROW_W'(1)};
        end
        else if (cmd.gen_wb)
        begin
            rd_en   = 1'b1;
            rd_addr = {bank_reg, lsg_pkg::ROW_W'(gen_row_reg + 2'd2)};
        end

        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, clr_row_reg};
        end
        else if (cmd.rw_finish && addr_hit && item_reg.func == lsg_pkg::FUNC_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = {bank_reg, item_row};
            wr_data = mod_row;
        end
        else if (cmd.gen_wb)
        begin
            wr_en   = 1'b1;
            wr_addr = {~bank_reg, lsg_pkg::ROW_W'(gen_row_reg)};
            wr_data = new_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // generation datapath
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
            item_reg <= in_item;
        if (cmd.gen_init)
            prev_reg <= '0;
        if (cmd.gen_fill)
            cur_reg <= rd_data_reg;
        if (cmd.gen_next)
            next_reg <= next_row_in ? rd_data_reg : '0;
        if (cmd.gen_cell)
            new_row_reg[2*gen_col_reg +: 2] <= new_cell;
        if (cmd.gen_wb)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= lsg_pkg::CCNT_W'(lsg_pkg::clamp_dim(7'd64, lsg_pkg::MAX_COLS));
            rows_reg      <= lsg_pkg::RCNT_W'(lsg_pkg::clamp_dim(7'd64, lsg_pkg::MAX_ROWS));
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            clr_row_reg   <= '0;
            gen_row_reg   <= '0;
            gen_col_reg   <= '0;
            rowmod_reg    <= '0;
            diag_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == lsg_pkg::CFG_COLS)
                cols_reg <= lsg_pkg::CCNT_W'(lsg_pkg::clamp_dim(cfg_data, lsg_pkg::MAX_COLS));
            if (cfg_valid && cfg_index == lsg_pkg::CFG_ROWS)
                rows_reg <= lsg_pkg::RCNT_W'(lsg_pkg::clamp_dim(cfg_data, lsg_pkg::MAX_ROWS));

            if (cmd.clr_step)
                clr_row_reg <= clr_row_reg + 1'b1;

            if (cmd.rw_finish)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= rw_out;
            end
            else if (cmd.gen_flip)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= '{cell_out: 2'b00, buildable: 1'b0, in_grid: 1'b0,
                                   done_res: 1'b1};
                bank_reg      <= ~bank_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.gen_init)
            begin
                gen_row_reg <= '0;
                rowmod_reg  <= '0;
            end
            if (cmd.gen_next)
            begin
                gen_col_reg <= '0;
                diag_reg    <= rowmod_reg;
            end
            if (cmd.gen_cell)
            begin
                gen_col_reg <= gen_col_reg + 1'b1;
                diag_reg    <= (diag_reg == 3'd6) ? 3'd0 : diag_reg + 1'b1;
            end
            if (cmd.gen_wb)
            begin
                gen_row_reg <= gen_row_reg + 1'b1;
                rowmod_reg  <= (rowmod_reg == 3'd6) ? 3'd0 : rowmod_reg + 1'b1;
            end
        end
    end

    assign status.clr_last = (clr_row_reg == lsg_pkg::ROW_W'(lsg_pkg::MAX_ROWS - 1));
    assign status.func     = item_reg.func;
    assign status.col_last = (lsg_pkg::CCNT_W'(gen_col_reg) + 1'b1) == cols_reg;
    assign status.row_last = (gen_row_reg + 1'b1) == rows_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

endmodule
